>>> src/rsa_chained_token_decrypt_unit_macros.svh
// Assertion macros shared by the RTL of the chained token decrypt unit.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RSA_CHAINED_TOKEN_DECRYPT_UNIT_MACROS_SVH
`define RSA_CHAINED_TOKEN_DECRYPT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define RCD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define RCD_ASSERT(lbl, prop, msg)
`define RCD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

>>> src/rcd_pkg.sv
package rcd_pkg;

  localparam int unsigned OpWidthDef = 32;
  localparam int unsigned FieldW     = 32;
  localparam int unsigned CharW      = 8;
  localparam int unsigned CfgIdxW    = 1;
  localparam logic [FieldW-1:0] RstExp = 32'd32969;
  localparam logic [FieldW-1:0] RstMod = 32'd82333;

  typedef enum logic [1:0] {
    ACT_NONCE = 2'd0,
    ACT_START = 2'd1,
    ACT_DATA  = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXP = 1'b0,
    CFG_MOD = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [FieldW-1:0] token_value;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] plain_value;
    logic [CharW-1:0]  plain_char;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_CHAIN_RAW = 4'd1,
    OP_ZERO_ACC  = 4'd2,
    OP_RED_INIT  = 4'd3,
    OP_MUL_STEP  = 4'd4,
    OP_EXP_INIT  = 4'd5,
    OP_MUL_INIT  = 4'd6,
    OP_EXP_UPD   = 4'd7,
    OP_FINISH    = 4'd8
  } uop_e;

  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_NO_IN     = 3'd1,
    C_NOT_EXP   = 3'd2,
    C_SMALL_MOD = 3'd3,
    C_MUL_BUSY  = 3'd4,
    C_EXP_MORE  = 3'd5,
    C_OUT_FULL  = 3'd6
  } cond_e;

  localparam int unsigned PcW = 4;

  localparam logic [PcW-1:0] PC_IDLE     = 4'd0;
  localparam logic [PcW-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PcW-1:0] PC_CHECKM   = 4'd2;
  localparam logic [PcW-1:0] PC_RED_INIT = 4'd3;
  localparam logic [PcW-1:0] PC_RED_STEP = 4'd4;
  localparam logic [PcW-1:0] PC_EXP_INIT = 4'd5;
  localparam logic [PcW-1:0] PC_MUL_INIT = 4'd6;
  localparam logic [PcW-1:0] PC_MUL_STEP = 4'd7;
  localparam logic [PcW-1:0] PC_EXP_UPD  = 4'd8;
  localparam logic [PcW-1:0] PC_FINISH   = 4'd9;

  // One control word: operation, jump condition, jump target, and a flag
  // that sends a not-taken jump back to the idle step.
  typedef struct packed {
    uop_e           op;
    cond_e          cond;
    logic [PcW-1:0] target;
    logic           ret;
  } ucw_t;

  // Datapath status the sequencer tests.
  typedef struct packed {
    logic in_valid;
    logic not_exp;
    logic small_mod;
    logic mul_busy;
    logic exp_more;
    logic out_full;
  } seq_stat_t;

  function automatic ucw_t ucode_rom(logic [PcW-1:0] pc);
    ucw_t w;
    w = '{op: OP_NONE, cond: C_NEVER, target: PC_IDLE, ret: 1'b1};
    unique case (pc)
      PC_IDLE:     w = '{op: OP_NONE,      cond: C_NO_IN,     target: PC_IDLE,     ret: 1'b0};
      PC_DISPATCH: w = '{op: OP_CHAIN_RAW, cond: C_NOT_EXP,   target: PC_IDLE,     ret: 1'b0};
      PC_CHECKM:   w = '{op: OP_ZERO_ACC,  cond: C_SMALL_MOD, target: PC_FINISH,   ret: 1'b0};
      PC_RED_INIT: w = '{op: OP_RED_INIT,  cond: C_NEVER,     target: PC_IDLE,     ret: 1'b0};
      PC_RED_STEP: w = '{op: OP_MUL_STEP,  cond: C_MUL_BUSY,  target: PC_RED_STEP, ret: 1'b0};
      PC_EXP_INIT: w = '{op: OP_EXP_INIT,  cond: C_NEVER,     target: PC_IDLE,     ret: 1'b0};
      PC_MUL_INIT: w = '{op: OP_MUL_INIT,  cond: C_NEVER,     target: PC_IDLE,     ret: 1'b0};
      PC_MUL_STEP: w = '{op: OP_MUL_STEP,  cond: C_MUL_BUSY,  target: PC_MUL_STEP, ret: 1'b0};
      PC_EXP_UPD:  w = '{op: OP_EXP_UPD,   cond: C_EXP_MORE,  target: PC_MUL_INIT, ret: 1'b0};
      PC_FINISH:   w = '{op: OP_FINISH,    cond: C_OUT_FULL,  target: PC_FINISH,   ret: 1'b1};
      default:     w = '{op: OP_NONE,      cond: C_NEVER,     target: PC_IDLE,     ret: 1'b1};
    endcase
    return w;
  endfunction

endpackage

>>> src/rcd_mm_lane.sv
// Bit-serial interleaved modular multiply lane: r = 2r + bit*addend mod m.
module rcd_mm_lane import rcd_pkg::*; #(
  parameter int unsigned W = OpWidthDef
) (
  input  logic         clk_i,
  input  logic         clr_i,
  input  logic         step_i,
  input  logic         bit_i,
  input  logic [W-1:0] addend_i,
  input  logic [W-1:0] mod_i,
  output logic [W-1:0] r_o
);

  logic [W-1:0] r_q, r_d;
  logic [W:0]   m_ext, t, t1, u, u1;

  always_comb begin
    m_ext = {1'b0, mod_i};
    t     = {r_q, 1'b0};
    t1    = (t >= m_ext) ? (t - m_ext) : t;
    u     = {1'b0, t1[W-1:0]} + {1'b0, (bit_i ? addend_i : {W{1'b0}})};
    u1    = (u >= m_ext) ? (u - m_ext) : u;
    r_d   = r_q;
    if (clr_i) begin
      r_d = '0;
    end else if (step_i) begin
      r_d = u1[W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign r_o = r_q;

endmodule

>>> src/rcd_sequencer.sv
// Step counter over the control ROM with conditional jumps.
module rcd_sequencer import rcd_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  seq_stat_t      stat_i,
  output ucw_t           cw_o,
  output logic [PcW-1:0] pc_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ucw_t           cw;
  logic           take;

  always_comb begin
    cw = ucode_rom(pc_q);
    unique case (cw.cond)
      C_NEVER:     take = 1'b0;
      C_NO_IN:     take = !stat_i.in_valid;
      C_NOT_EXP:   take = stat_i.not_exp;
      C_SMALL_MOD: take = stat_i.small_mod;
      C_MUL_BUSY:  take = stat_i.mul_busy;
      C_EXP_MORE:  take = stat_i.exp_more;
      C_OUT_FULL:  take = stat_i.out_full;
      default:     take = 1'b0;
    endcase
    if (take) begin
      pc_d = cw.target;
    end else if (cw.ret) begin
      pc_d = PC_IDLE;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign cw_o = cw;
  assign pc_o = pc_q;

endmodule

>>> src/rsa_chained_token_decrypt_unit.sv
// Chained RSA token decryptor.
// Input channel (in_valid_i / in_stall_o / in_item_i) takes one item per
// token: an action code and a ciphertext value. Output channel (out_valid_o /
// out_stall_i / out_item_o) delivers one item per data token: the decrypted
// value XOR the chain, and its low byte as the character.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 private exponent, 1 modulus); write only while the block is idle.
// Throughput is one item at a time. A microcoded sequencer walks a ten-step
// control ROM over a bit-serial modular multiplier with two lanes, one
// multiplier bit per cycle. A nonce or data item first reduces the base,
// then each of W exponent bits runs the shared multiply and square pass. A
// chain start and an unused action code return to idle after dispatch; a
// modulus below two skips to the finish step with a zero accumulator.
// Reset clears the sequencer, the chain, the output valid and loads the
// default exponent and modulus. A stalled output holds its item; the block
// still accepts the next item, and a nonce load or data token waits at its
// last step for as long as the output is still full.
`include "rsa_chained_token_decrypt_unit_macros.svh"

module rsa_chained_token_decrypt_unit import rcd_pkg::*; #(
  parameter int unsigned OPERAND_WIDTH = OpWidthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [FieldW-1:0]    cfg_wdata_i
);

  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned CW = $clog2(W);
  localparam logic [W-1:0] ExpRst = RstExp[W-1:0];
  localparam logic [W-1:0] ModRst = RstMod[W-1:0];

  ucw_t           cw;
  logic [PcW-1:0] pc;
  seq_stat_t      stat;

  // Control state
  logic [W-1:0]  exp_q, mod_q, chain_q;
  logic          out_valid_q;
  // Working registers
  logic [1:0]    act_q;
  logic [W-1:0]  tok_q, acc_q, sq_q, x_q, e_q;
  logic [CW-1:0] cnt_q, ecnt_q;
  out_item_t     out_q;

  logic [W-1:0]  ra, rs, plain;
  logic          in_acc, out_take, out_full, finish_fire, lane_clr, lane_step;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_full    = out_valid_q && out_stall_i;
  assign finish_fire = (cw.op == OP_FINISH) && !out_full;
  assign lane_clr    = (cw.op == OP_RED_INIT) || (cw.op == OP_MUL_INIT);
  assign lane_step   = (cw.op == OP_MUL_STEP);
  assign plain       = acc_q ^ chain_q;

  always_comb begin
    stat.in_valid  = in_valid_i;
    stat.not_exp   = !((act_q == ACT_NONCE) || (act_q == ACT_DATA));
    stat.small_mod = (mod_q[W-1:1] == '0);
    stat.mul_busy  = (cnt_q != '0);
    stat.exp_more  = (ecnt_q != '0);
    stat.out_full  = out_full;
  end

  rcd_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cw_o   (cw),
    .pc_o   (pc)
  );

  // Lane a: acc * sq (or base * 1 during the reduction pass).
  rcd_mm_lane #(.W(W)) u_lane_a (
    .clk_i    (clk_i),
    .clr_i    (lane_clr),
    .step_i   (lane_step),
    .bit_i    (x_q[W-1]),
    .addend_i (acc_q),
    .mod_i    (mod_q),
    .r_o      (ra)
  );

  // Lane s: sq * sq, sharing the multiplier bits of lane a.
  rcd_mm_lane #(.W(W)) u_lane_s (
    .clk_i    (clk_i),
    .clr_i    (lane_clr),
    .step_i   (lane_step),
    .bit_i    (x_q[W-1]),
    .addend_i (sq_q),
    .mod_i    (mod_q),
    .r_o      (rs)
  );

  // Config, chain and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= ExpRst;
      mod_q       <= ModRst;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_EXP: exp_q <= cfg_wdata_i[W-1:0];
          CFG_MOD: mod_q <= cfg_wdata_i[W-1:0];
          default: ;
        endcase
      end
      if (out_take) begin
        out_valid_q <= 1'b0;
      end
      // Raw chain start
      if ((cw.op == OP_CHAIN_RAW) && (act_q == ACT_START)) begin
        chain_q <= tok_q;
      end
      if (finish_fire) begin
        case (act_q)
          ACT_NONCE: chain_q <= acc_q;
          ACT_DATA: begin
            chain_q     <= tok_q;
            out_valid_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= in_item_i.action;
      tok_q <= in_item_i.token_value[W-1:0];
    end
    case (cw.op)
      OP_ZERO_ACC: acc_q <= '0;
      OP_RED_INIT: begin
        // Reduce the base as base * 1 mod m.
        acc_q <= {{(W-1){1'b0}}, 1'b1};
        x_q   <= tok_q;
        cnt_q <= CW'(W - 1);
      end
      OP_MUL_STEP: begin
        x_q   <= {x_q[W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
      end
      OP_EXP_INIT: begin
        sq_q   <= ra;
        acc_q  <= {{(W-1){1'b0}}, 1'b1};
        e_q    <= exp_q;
        ecnt_q <= CW'(W - 1);
      end
      OP_MUL_INIT: begin
        x_q   <= sq_q;
        cnt_q <= CW'(W - 1);
      end
      OP_EXP_UPD: begin
        if (e_q[0]) begin
          acc_q <= ra;
        end
        sq_q   <= rs;
        e_q    <= {1'b0, e_q[W-1:1]};
        ecnt_q <= ecnt_q - 1'b1;
      end
      default: ;
    endcase
    if (finish_fire && (act_q == ACT_DATA)) begin
      out_q.plain_value <= FieldW'(plain);
      out_q.plain_char  <= plain[CharW-1:0];
    end
  end

  assign in_stall_o  = (pc != PC_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RCD_ASSERT_NEXT(a_accept_dispatch, in_valid_i && !in_stall_o, pc == PC_DISPATCH, "accept did not dispatch")
  `RCD_ASSERT_NEXT(a_cnt_down, cw.op == OP_MUL_STEP && cnt_q != '0, cnt_q == $past(cnt_q) - 1'b1, "multiply step count skipped")
  `RCD_ASSERT(a_acc_range, (pc >= PC_RED_INIT && pc <= PC_EXP_UPD) |-> (acc_q < mod_q), "accumulator not reduced")
  `RCD_ASSERT_NEXT(a_out_src, !out_valid_q && !(cw.op == OP_FINISH && act_q == ACT_DATA), !out_valid_q, "output valid without a data token")

endmodule
